[src/png_unf_pkg.sv]
`timescale 1ns / 1ps

package png_unf_pkg;

  // sizing
  localparam int MaxRowBytes   = 4096;
  localparam int MaxPixelBytes = 8;
  localparam int ColW  = $clog2(MaxRowBytes + 1);
  localparam int IdxW  = (MaxRowBytes > 1) ? $clog2(MaxRowBytes) : 1;
  localparam int LaneW = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;

  // register fields and apb port
  localparam int BppW   = 4;
  localparam int RowW   = 13;
  localparam int AddrW  = 3;
  localparam int PDataW = 32;

  localparam logic [BppW-1:0] BppReset = 4'd4;
  localparam logic [RowW-1:0] RowReset = 13'd1024;

  // register indexes, decoded from the word address bit
  localparam logic RegBpp      = 1'b0;
  localparam logic RegRowBytes = 1'b1;

  localparam logic [7:0] FiltMaxCode = 8'd4;

  typedef enum logic [2:0] {
    FiltNone  = 3'd0,
    FiltSub   = 3'd1,
    FiltUp    = 3'd2,
    FiltAvg   = 3'd3,
    FiltPaeth = 3'd4,
    FiltBad   = 3'd5
  } filt_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_end;
    logic       bad_filter;
  } out_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [BppW-1:0] bpp;
    logic [ColW-1:0] row_bytes;
  } cfg_t;

  // one beat as it sits in the reconstruction stage
  typedef struct packed {
    logic [7:0]       data;
    filt_e            filter;
    logic             is_data;
    logic [IdxW-1:0]  idx;
    logic [LaneW-1:0] lane;
    logic             has_left;
    logic             b_valid;
    logic             row_end;
  } item_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [7:0]      data;
  } ram_wr_t;

  // paeth predictor, ties go to left then up
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [9:0] s_ab;
    logic [9:0] s_cc;
    logic [7:0] r;
    pa   = (b >= c) ? 10'(b - c) : 10'(c - b);
    pb   = (a >= c) ? 10'(a - c) : 10'(c - a);
    s_ab = 10'(a) + 10'(b);
    s_cc = {1'b0, c, 1'b0};
    pc   = (s_ab >= s_cc) ? (s_ab - s_cc) : (s_cc - s_ab);
    if ((pa <= pb) && (pa <= pc)) begin
      r = a;
    end else if (pb <= pc) begin
      r = b;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

[src/png_unf_ram.sv]
`timescale 1ns / 1ps

module png_unf_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/png_unf_cfg.sv]
`timescale 1ns / 1ps

module png_unf_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [png_unf_pkg::AddrW-1:0]  paddr,
  input  logic [png_unf_pkg::PDataW-1:0] pwdata,
  output logic [png_unf_pkg::PDataW-1:0] prdata,
  output logic                          pready,
  output png_unf_pkg::cfg_t             cfg_o
);
  import png_unf_pkg::*;

  logic [BppW-1:0] bpp_q;
  logic [RowW-1:0] row_q;
  logic            wr_en;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[AddrW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= BppReset;
      row_q <= RowReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegBpp:      bpp_q <= pwdata[BppW-1:0];
        RegRowBytes: row_q <= pwdata[RowW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegBpp:      prdata = PDataW'(bpp_q);
      RegRowBytes: prdata = PDataW'(row_q);
      default:     prdata = '0;
    endcase
  end

  // out-of-range settings clamp to the nearest legal value
  always_comb begin
    if (bpp_q == '0) begin
      cfg_o.bpp = BppW'(1);
    end else if (32'(bpp_q) > 32'(MaxPixelBytes)) begin
      cfg_o.bpp = BppW'(MaxPixelBytes);
    end else begin
      cfg_o.bpp = bpp_q;
    end
    if (row_q == '0) begin
      cfg_o.row_bytes = ColW'(1);
    end else if (32'(row_q) > 32'(MaxRowBytes)) begin
      cfg_o.row_bytes = ColW'(MaxRowBytes);
    end else begin
      cfg_o.row_bytes = ColW'(row_q);
    end
  end

endmodule

[src/png_unf_recon.sv]
`timescale 1ns / 1ps

module png_unf_recon (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  png_unf_pkg::item_t   item_i,
  input  logic                 clear_i,
  input  logic [7:0]           rdata_i,
  output logic                 s1_ready_o,
  output png_unf_pkg::ram_wr_t ram_wr_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output png_unf_pkg::out_t    out_data_o
);
  import png_unf_pkg::*;

  logic       s1_valid_q;
  item_t      s1_q;
  logic       ob_valid_q;
  out_t       ob_q;
  logic [7:0] left_q [MaxPixelBytes];
  logic [7:0] upl_q  [MaxPixelBytes];

  logic       fire;
  logic       emit;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] sum_ab;
  logic [7:0] pred;
  logic [7:0] res;

  assign b = s1_q.b_valid ? rdata_i : 8'd0;
  assign a = s1_q.has_left ? left_q[s1_q.lane] : 8'd0;
  assign c = s1_q.has_left ? upl_q[s1_q.lane] : 8'd0;
  assign sum_ab = 9'(a) + 9'(b);

  always_comb begin
    case (s1_q.filter)
      FiltSub:   pred = a;
      FiltUp:    pred = b;
      FiltAvg:   pred = sum_ab[8:1];
      FiltPaeth: pred = paeth(a, b, c);
      default:   pred = 8'd0;
    endcase
  end

  assign res = s1_q.data + pred;

  // filter beats leave without a result, data beats need room downstream
  assign fire = s1_valid_q && (!s1_q.is_data || !ob_valid_q || out_ready_i);
  assign emit = fire && s1_q.is_data;
  assign s1_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      ob_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (emit) begin
        ob_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        ob_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= item_i;
    end
    if (emit) begin
      ob_q.out_byte   <= res;
      ob_q.row_end    <= s1_q.row_end;
      ob_q.bad_filter <= (s1_q.filter == FiltBad);
    end
  end

  // neighbor bytes; start of image wipes them after the last write of the old image
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxPixelBytes; k++) begin
        left_q[k] <= 8'd0;
        upl_q[k]  <= 8'd0;
      end
    end else if (clear_i) begin
      for (int k = 0; k < MaxPixelBytes; k++) begin
        left_q[k] <= 8'd0;
        upl_q[k]  <= 8'd0;
      end
    end else if (emit) begin
      left_q[s1_q.lane] <= res;
      upl_q[s1_q.lane]  <= b;
    end
  end

  assign ram_wr_o.we   = emit;
  assign ram_wr_o.addr = s1_q.idx;
  assign ram_wr_o.data = res;

  assign out_valid_o = ob_valid_q;
  assign out_data_o  = ob_q;

endmodule

[src/png_scanline_unfilter_top.sv]
`timescale 1ns / 1ps
// channel  | signals                               | beat
// in       | in_valid_i / in_ready_o / in_data_i   | one filtered byte, start_of_image flag
// out      | out_valid_o / out_ready_i / out_data_o| one reconstructed byte, row_end, bad_filter
// config   | psel penable pwrite paddr pwdata ...  | bytes_per_pixel at 0, row_bytes at 4
//
// one beat per cycle sustained while out is not stalled; a data byte reaches out through
// the prior-row ram read, then the predictor stage into the output register
// filter-type bytes travel the pipe but give no output beat
// reset needs no clearing pass: a fill count marks how much of the prior-row ram is
// written since start of image, the rest reads as zero
// out stall holds the output register, then the predictor stage, then in_ready_o

module png_scanline_unfilter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  png_unf_pkg::in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output png_unf_pkg::out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [png_unf_pkg::AddrW-1:0]  paddr,
  input  logic [png_unf_pkg::PDataW-1:0] pwdata,
  output logic [png_unf_pkg::PDataW-1:0] prdata,
  output logic                          pready
);
  import png_unf_pkg::*;

  cfg_t    cfg;
  item_t   item;
  ram_wr_t ram_wr;
  logic    s1_ready;
  logic [7:0] rdata;

  // column state: 0 expects a filter byte, k means data byte k-1 is next
  logic [ColW-1:0]  col_q, col_d;
  logic [ColW-1:0]  col_m1;
  // highest prefix of the prior-row ram written since start of image
  logic [ColW-1:0]  fill_q, fill_d;
  filt_e            row_filter_q, row_filter_d;
  // per-modulus position counters, lane = position mod bytes_per_pixel
  logic [LaneW-1:0] lane_cnt_q [MaxPixelBytes];

  logic             in_acc;
  logic             soi;
  logic             is_filter;
  logic [IdxW-1:0]  idx;
  logic [BppW-1:0]  bpp_m1;
  logic [LaneW-1:0] lane;
  logic             last;
  filt_e            new_filter;

  png_unf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = s1_ready;
  assign in_acc     = in_valid_i && in_ready_o;
  assign soi        = in_data_i.start_of_image;
  // start of image abandons any open row and takes this byte as filter type
  assign is_filter  = soi || (col_q == '0);

  assign col_m1 = col_q - ColW'(1);
  assign idx    = col_m1[IdxW-1:0];
  assign bpp_m1 = cfg.bpp - BppW'(1);
  assign lane   = lane_cnt_q[bpp_m1[LaneW-1:0]];
  assign last   = (col_q >= cfg.row_bytes);

  assign new_filter = (in_data_i.data_byte <= FiltMaxCode) ?
                      filt_e'(in_data_i.data_byte[2:0]) : FiltBad;

  always_comb begin
    col_d        = col_q;
    row_filter_d = row_filter_q;
    if (in_acc) begin
      if (is_filter) begin
        col_d        = ColW'(1);
        row_filter_d = new_filter;
      end else if (last) begin
        col_d = '0;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // writes within a row run from column zero upward, so the written set is a prefix
  always_comb begin
    fill_d = fill_q;
    if (ram_wr.we && (ColW'(ram_wr.addr) == fill_q)) begin
      fill_d = fill_q + ColW'(1);
    end
    if (in_acc && soi) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      fill_q       <= '0;
      row_filter_q <= FiltNone;
    end else begin
      col_q        <= col_d;
      fill_q       <= fill_d;
      row_filter_q <= row_filter_d;
    end
  end

  for (genvar g = 0; g < MaxPixelBytes; g++) begin : g_lane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lane_cnt_q[g] <= '0;
      end else if (in_acc) begin
        if (is_filter || (lane_cnt_q[g] == LaneW'(g))) begin
          lane_cnt_q[g] <= '0;
        end else begin
          lane_cnt_q[g] <= lane_cnt_q[g] + LaneW'(1);
        end
      end
    end
  end

  // beat handed to the predictor stage
  always_comb begin
    item.data     = in_data_i.data_byte;
    item.filter   = row_filter_q;
    item.is_data  = !is_filter;
    item.idx      = idx;
    item.lane     = lane;
    item.has_left = (ColW'(idx) >= ColW'(cfg.bpp));
    item.b_valid  = (ColW'(idx) < fill_q);
    item.row_end  = last;
  end

  // prior-row line buffer, read as the byte is taken, written as its result leaves
  png_unf_ram #(
    .Width (8),
    .Depth (MaxRowBytes)
  ) u_prior_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (in_acc && !is_filter),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  png_unf_recon u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_acc),
    .item_i      (item),
    .clear_i     (in_acc && soi),
    .rdata_i     (rdata),
    .s1_ready_o  (s1_ready),
    .ram_wr_o    (ram_wr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/png_unf_chk.sv]
`timescale 1ns / 1ps

module png_unf_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input png_unf_pkg::in_t              in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input png_unf_pkg::out_t             out_data_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [png_unf_pkg::AddrW-1:0]  paddr,
  input logic [png_unf_pkg::PDataW-1:0] pwdata,
  input logic [png_unf_pkg::PDataW-1:0] prdata,
  input logic                          pready
);
  import png_unf_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output beat changed while stalled");

  // a start-of-image byte is a filter byte and never makes a result
  a_soi_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.start_of_image) |=> ##1 !$rose(out_valid_o))
    else $error("result beat from a start-of-image byte");

  a_rd_bpp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[AddrW-1] == RegBpp)) |=>
    (!(psel && !pwrite && (paddr[AddrW-1] == RegBpp)) ||
     (prdata[BppW-1:0] == $past(pwdata[BppW-1:0]))))
    else $error("bytes_per_pixel readback mismatch");

  a_rd_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[AddrW-1] == RegRowBytes)) |=>
    (!(psel && !pwrite && (paddr[AddrW-1] == RegRowBytes)) ||
     (prdata[RowW-1:0] == $past(pwdata[RowW-1:0]))))
    else $error("row_bytes readback mismatch");

endmodule

bind png_scanline_unfilter_top png_unf_chk u_chk (.*);

[sim/png_scanline_unfilter_checker.sv]
`timescale 1ns / 1ps

module png_scanline_unfilter_checker
  import png_unf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_t               in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_t              out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [AddrW-1:0]  paddr_i,
  input  logic [PDataW-1:0] pwdata_i,
  input  logic              pready_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  logic [7:0]      row_above [MaxRowBytes];
  logic [7:0]      left_px   [MaxPixelBytes];
  logic [7:0]      upleft_px [MaxPixelBytes];
  int unsigned     col_pos;
  filt_e           cur_filter;
  logic [BppW-1:0] bpp_reg;
  logic [RowW-1:0] row_len_reg;
  out_t            recon_q [$];
  int unsigned     mismatches;

  function automatic void clear_image();
    for (int k = 0; k < MaxRowBytes; k++) row_above[k] = 8'd0;
    for (int k = 0; k < MaxPixelBytes; k++) begin
      left_px[k]   = 8'd0;
      upleft_px[k] = 8'd0;
    end
    col_pos = 0;
  endfunction

  // distances of a + b - c to a, b and c
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int da;
    int db;
    int dc;
    da = int'(b) - int'(c);
    db = int'(a) - int'(c);
    dc = int'(a) + int'(b) - 2 * int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  function automatic void take_beat(input in_t beat);
    int unsigned bpp;
    int unsigned rlen;
    int unsigned idx;
    int unsigned lane;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  pred;
    out_t        rec;
    bpp  = (bpp_reg == 0) ? 1 : (bpp_reg > MaxPixelBytes) ? MaxPixelBytes : bpp_reg;
    rlen = (row_len_reg == 0) ? 1 : (row_len_reg > MaxRowBytes) ? MaxRowBytes : row_len_reg;
    if (in_data_i.start_of_image) clear_image();
    if (col_pos == 0) begin
      cur_filter = (beat.data_byte <= FiltMaxCode) ? filt_e'(beat.data_byte[2:0]) : FiltBad;
      col_pos    = 1;
      return;
    end
    idx = col_pos - 1;
    if (idx >= MaxRowBytes) idx = MaxRowBytes - 1;
    lane = idx % bpp;
    b    = row_above[idx];
    a    = (idx >= bpp) ? left_px[lane] : 8'd0;
    c    = (idx >= bpp) ? upleft_px[lane] : 8'd0;
    case (cur_filter)
      FiltSub:   pred = a;
      FiltUp:    pred = b;
      FiltAvg:   pred = 8'((int'(a) + int'(b)) >> 1);
      FiltPaeth: pred = paeth_pick(a, b, c);
      default:   pred = 8'd0;
    endcase
    rec.out_byte    = beat.data_byte + pred;
    rec.row_end     = (idx + 1 >= rlen);
    rec.bad_filter  = (cur_filter == FiltBad);
    upleft_px[lane] = b;
    left_px[lane]   = rec.out_byte;
    row_above[idx]  = rec.out_byte;
    col_pos         = rec.row_end ? 0 : idx + 2;
    recon_q.push_back(rec);
  endfunction

  function automatic void check_beat(input out_t got);
    out_t want;
    if (recon_q.size() == 0) begin
      $display("%0t: out beat with none expected, actual byte %0d row_end %0b bad_filter %0b",
               $time, got.out_byte, got.row_end, got.bad_filter);
      mismatches++;
      return;
    end
    want = recon_q.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $display("%0t: out_byte expected %0d actual %0d", $time, want.out_byte, got.out_byte);
      mismatches++;
    end
    if (got.row_end !== want.row_end) begin
      $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, got.row_end);
      mismatches++;
    end
    if (got.bad_filter !== want.bad_filter) begin
      $display("%0t: bad_filter expected %0b actual %0b", $time, want.bad_filter,
               got.bad_filter);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_image();
      cur_filter  = FiltNone;
      bpp_reg     = BppReset;
      row_len_reg = RowReset;
      recon_q.delete();
      mismatches  = 0;
    end else begin
      // a beat leaving now was taken in an earlier cycle
      if (out_valid_i && out_ready_i) check_beat(out_data_i);
      if (in_valid_i && in_ready_i) take_beat(in_data_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[AddrW-1] == RegRowBytes) begin
          row_len_reg = pwdata_i[RowW-1:0];
        end else begin
          bpp_reg = pwdata_i[BppW-1:0];
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= recon_q.size();
  end

endmodule

[sim/png_scanline_unfilter_top_tb.sv]
`timescale 1ns / 1ps

module png_scanline_unfilter_top_tb;
  import png_unf_pkg::*;

  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 9;
  localparam int MaxGap      = 14;
  localparam int RandomItems = 1100;
  // a trailing filter byte leaves no result to wait on
  localparam int PipePause   = 4;
  // one long out-side hold-off so the pipe fills and in_ready drops
  localparam int HoldBeat    = 300;
  localparam int HoldCycles  = 400;
  localparam int LimitNs     = 4_000_000;
  // wide-pixel rows at the end
  localparam int WideRowLen  = 64;
  localparam int ClampBytes  = 40;

  localparam logic [AddrW-1:0] AddrBpp      = {RegBpp, 2'b00};
  localparam logic [AddrW-1:0] AddrRowBytes = {RegRowBytes, 2'b00};

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [AddrW-1:0]  paddr     = '0;
  logic [PDataW-1:0] pwdata    = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;
  int unsigned       errors;
  int unsigned       pending;

  // stimulus-side bookkeeping only
  bit                no_gaps    = 1'b0;
  int unsigned       sent_items = 0;
  int unsigned       row_len    = RowReset;

  png_scanline_unfilter_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  png_scanline_unfilter_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #(HalfPeriod) clk = ~clk;

  // hard stop in case a handshake never completes
  initial begin
    #(LimitNs);
    $display("png_scanline_unfilter_top_tb failed");
    $finish;
  end

  // one in beat: optional idle gap, then hold valid until taken
  task automatic send_beat(input logic [7:0] val, input bit soi);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{data_byte: val, start_of_image: soi};
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent_items++;
  endtask

  // filter byte then n data bytes; fill < 0 means random content
  task automatic send_row(input logic [7:0] filt, input bit soi, input int unsigned n,
                          input int fill);
    send_beat(filt, soi);
    for (int unsigned k = 0; k < n; k++)
      send_beat((fill < 0) ? 8'($urandom) : 8'(fill), 1'b0);
  endtask

  // setup phase, access phase, then idle so back-to-back writes stay clean
  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [PDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are don't-care, so they carry noise
  task automatic configure(input bit wr_bpp, input int unsigned bpp_val, input bit wr_rows,
                           input int unsigned rows_val);
    logic [PDataW-1:0] word;
    if (wr_bpp) begin
      word = $urandom;
      word[BppW-1:0] = bpp_val[BppW-1:0];
      reg_write(AddrBpp, word);
    end
    if (wr_rows) begin
      word = $urandom;
      word[RowW-1:0] = rows_val[RowW-1:0];
      reg_write(AddrRowBytes, word);
      // clamped length, used to shape well-formed rows
      row_len = (rows_val == 0) ? 1 : (rows_val > MaxRowBytes) ? MaxRowBytes : rows_val;
    end
  endtask

  // stop offering, wait for the last result, then let trailing filter bytes settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PipePause) @(posedge clk);
  endtask

  // mostly the five known filters, sometimes an unknown code
  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(int'(FiltMaxCode) + 1, 255));
    return 8'($urandom_range(int'(FiltNone), int'(FiltPaeth)));
  endfunction

  // out side: random stall per beat, one long hold-off, none while no_gaps is set
  initial begin : out_side
    int unsigned stall;
    int unsigned beats;
    beats = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (beats == HoldBeat) begin
        stall = HoldCycles;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, MaxGap);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      beats++;
    end
  end

  initial begin : stimulus
    int unsigned base;
    int unsigned nrows;
    int unsigned n;
    int unsigned bpp_v;
    int unsigned rows_v;
    bit          soi;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two-byte pixels, three-byte rows, each filter, byte extremes
    configure(1'b1, 2, 1'b1, 3);
    send_row(8'(FiltNone),  1'b1, 3, 255);
    send_row(8'(FiltSub),   1'b0, 3, 255);
    send_row(8'(FiltUp),    1'b0, 3, 0);
    send_row(8'(FiltAvg),   1'b0, 3, 255);
    send_row(8'(FiltPaeth), 1'b0, 3, -1);
    // unknown filter code: raw pass-through with the error flag
    send_row(8'hff,         1'b0, 3, 0);
    drain_pipe();

    // random phases: new settings, a run of rows, some broken ones and loose bytes
    base = sent_items;
    while (sent_items - base < RandomItems) begin
      no_gaps <= ($urandom_range(0, 4) == 0);
      // pixel size incl. zero and values past the max
      case ($urandom_range(0, 5))
        0:       bpp_v = 0;
        1:       bpp_v = 1;
        2:       bpp_v = MaxPixelBytes;
        3:       bpp_v = (1 << BppW) - 1;
        default: bpp_v = $urandom_range(0, (1 << BppW) - 1);
      endcase
      // short rows keep the item count sane
      case ($urandom_range(0, 7))
        0:       rows_v = 0;
        1:       rows_v = 1;
        default: rows_v = $urandom_range(2, 24);
      endcase
      // a phase may leave the block mid-row, so a write here can change
      // the row length or pixel size in the middle of a row
      configure($urandom_range(0, 1), bpp_v, $urandom_range(0, 1), rows_v);
      nrows = $urandom_range(1, 6);
      for (int unsigned r = 0; r < nrows; r++) begin
        soi = (r == 0) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 19) == 0);
        n   = row_len;
        // cut-short row: the next filter byte lands as data
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, row_len);
        send_row(pick_filter(), soi, n, -1);
      end
      // loose bytes, sometimes with start of image mid-row
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6)) send_beat(8'($urandom), ($urandom_range(0, 3) == 0));
      end
      drain_pipe();
    end

    // widest pixels: eight-byte pixels over longer rows, no idling
    no_gaps <= 1'b1;
    configure(1'b1, MaxPixelBytes, 1'b1, WideRowLen);
    send_row(8'(FiltSub), 1'b1, row_len, -1);
    send_row(8'($urandom_range(int'(FiltUp), int'(FiltPaeth))), 1'b0, row_len, -1);
    drain_pipe();
    // row length past the max clamps to the full row, so a short run never ends the row
    configure(1'b0, 0, 1'b1, (1 << RowW) - 1);
    send_row(8'($urandom_range(int'(FiltUp), int'(FiltPaeth))), 1'b0, ClampBytes, -1);
    drain_pipe();

    // quiet tail to catch stray out beats
    repeat (2 * PipePause) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("png_scanline_unfilter_top_tb passed");
    end else begin
      $display("png_scanline_unfilter_top_tb failed");
    end
    $finish;
  end

endmodule
